// ===== rtl/bpfa_pkg.sv =====
package bpfa_pkg;

  // sizes of the frame maps
  localparam int unsigned MaxFrames = 65536;
  localparam int unsigned FrameW    = 17;
  localparam int unsigned WordBits  = 64;
  localparam int unsigned BitW      = 6;
  localparam int unsigned MapWords  = MaxFrames / WordBits;
  localparam int unsigned WaddrW    = 10;
  localparam int unsigned MemW      = 2 * WordBits;
  localparam int unsigned AddrW     = 52;
  localparam int unsigned MaxPhysW  = 29;

  localparam logic [FrameW-1:0] MAX_FRAMES_C = FrameW'(MaxFrames);

  // configuration register indexes
  localparam logic CFG_TOTAL_FRAMES = 1'b0;
  localparam logic CFG_MAX_PHYS     = 1'b1;

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_FREE    = 3'd1,
    OP_QUERY   = 3'd2,
    OP_ADD     = 3'd3,
    OP_RESERVE = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OOM       = 3'd1,
    ST_UNALIGNED = 3'd2,
    ST_BOUNDS    = 3'd3,
    ST_UNUSABLE  = 3'd4,
    ST_DOUBLE    = 3'd5,
    ST_CORRUPT   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SETUP,
    S_MOD,
    S_OUT
  } state_e;

  // one map word access: write port plus read address
  typedef struct packed {
    logic              we;
    logic [WaddrW-1:0] waddr;
    logic [MemW-1:0]   wdata;
    logic [WaddrW-1:0] raddr;
  } mem_req_t;

  // bits of word w that lie in [lo, hi)
  function automatic logic [WordBits-1:0] word_mask(input logic [WaddrW-1:0] w,
                                                    input logic [FrameW-1:0] lo,
                                                    input logic [FrameW-1:0] hi);
    logic [WordBits-1:0] lower;
    logic [WordBits-1:0] upper;
    lower = ({1'b0, w} == lo[FrameW-1:BitW]) ? ({WordBits{1'b1}} << lo[BitW-1:0])
                                             : {WordBits{1'b1}};
    upper = ({1'b0, w} == hi[FrameW-1:BitW]) ? ~({WordBits{1'b1}} << hi[BitW-1:0])
                                             : {WordBits{1'b1}};
    return lower & upper;
  endfunction

  // position of the lowest set bit
  function automatic logic [BitW-1:0] lowest_bit(input logic [WordBits-1:0] v);
    logic [BitW-1:0] pos;
    pos = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (v[i]) pos = BitW'(i);
    end
    return pos;
  endfunction

endpackage

// ===== rtl/bitmap_page_frame_allocator.sv =====
// Page frame allocator for 4 KiB frames, keeping an allocated and a usable
// bitmap in one 1024 x 128 bit map memory (64 frames per word).
// Request channel: in_valid_i / in_stall_o with operation, phys_addr and
// range_end; one request is taken at a time. Result channel: out_valid_o /
// out_stall_i with status, frame address, query answer and free count,
// exactly one result per request.
// Each accepted request passes S_SETUP and S_OUT; requests that pass
// their checks visit S_MOD in between, failed checks and unknown operations
// skip it. S_MOD is the single read-modify-write loop over the map memory:
// free and query visit one map word, allocate and range operations walk theirs.
// A new request is taken while the previous result still waits in the
// output register; the next result waits until that one is taken.
// Reset: a clearing pass over the 1024 map words marks all frames allocated and
// unusable; in_stall_o stays high meanwhile. Free count and hint reset to
// zero, total_frames to 65536, max_phys_addr to 2^28.
// Configuration writes (cfg_ready_o always high) belong in idle periods.
module bitmap_page_frame_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    in_operation_i,
  input  logic [bpfa_pkg::AddrW-1:0]    in_phys_addr_i,
  input  logic [bpfa_pkg::AddrW-1:0]    in_range_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    out_status_o,
  output logic [27:0]                   out_frame_addr_o,
  output logic                          out_is_allocated_o,
  output logic [bpfa_pkg::FrameW-1:0]   out_free_frames_now_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [bpfa_pkg::MaxPhysW-1:0] cfg_data_i
);
  import bpfa_pkg::*;

  logic [FrameW-1:0]   total_q;
  logic [MaxPhysW-1:0] max_phys_q;
  logic [FrameW-1:0]   eff_total;
  mem_req_t            mem_req;
  logic [MemW-1:0]     mem_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= MAX_FRAMES_C;
      max_phys_q <= MaxPhysW'(268435456);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_TOTAL_FRAMES: total_q    <= cfg_data_i[FrameW-1:0];
        CFG_MAX_PHYS:     max_phys_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign eff_total   = (total_q > MAX_FRAMES_C) ? MAX_FRAMES_C : total_q;

  bpfa_map_ram #(
    .ADDR_W (WaddrW),
    .DATA_W (MemW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  bpfa_engine u_engine (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .in_operation_i        (in_operation_i),
    .in_phys_addr_i        (in_phys_addr_i),
    .in_range_end_i        (in_range_end_i),
    .eff_total_i           (eff_total),
    .max_phys_i            (max_phys_q),
    .mem_req_o             (mem_req),
    .mem_rdata_i           (mem_rdata),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_status_o          (out_status_o),
    .out_frame_addr_o      (out_frame_addr_o),
    .out_is_allocated_o    (out_is_allocated_o),
    .out_free_frames_now_o (out_free_frames_now_o)
  );

  // free count never passes the map size
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_free_frames_now_o <= MAX_FRAMES_C)
    else $error("free count above map size");

  // a frame address comes only with a good status
  a_faddr_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o != ST_OK) |-> out_frame_addr_o == '0)
    else $error("frame address on failed request");

  // query answer only with a good status
  a_isal_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_is_allocated_o) |-> out_status_o == ST_OK)
    else $error("query answer on failed request");

endmodule

// ===== rtl/bpfa_map_ram.sv =====
module bpfa_map_ram #(
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 128
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/bpfa_engine.sv =====
module bpfa_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     in_operation_i,
  input  logic [bpfa_pkg::AddrW-1:0]     in_phys_addr_i,
  input  logic [bpfa_pkg::AddrW-1:0]     in_range_end_i,
  input  logic [bpfa_pkg::FrameW-1:0]    eff_total_i,
  input  logic [bpfa_pkg::MaxPhysW-1:0]  max_phys_i,
  output bpfa_pkg::mem_req_t             mem_req_o,
  input  logic [bpfa_pkg::MemW-1:0]      mem_rdata_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     out_status_o,
  output logic [27:0]                    out_frame_addr_o,
  output logic                           out_is_allocated_o,
  output logic [bpfa_pkg::FrameW-1:0]    out_free_frames_now_o
);
  import bpfa_pkg::*;

  state_e              state_q, state_d;
  logic [2:0]          op_q, op_d;
  logic [AddrW-1:0]    base_q, base_d;
  logic [AddrW-1:0]    end_q, end_d;
  logic [WaddrW-1:0]   w_q, w_d;
  logic [FrameW-1:0]   lo_q, lo_d;
  logic [FrameW-1:0]   hi_q, hi_d;
  logic                pass2_q, pass2_d;
  logic [FrameW-1:0]   free_q, free_d;
  logic [FrameW-1:0]   hint_q, hint_d;
  logic [2:0]          res_status_q, res_status_d;
  logic [27:0]         res_faddr_q, res_faddr_d;
  logic                res_isal_q, res_isal_d;
  logic                out_valid_q, out_valid_d;
  logic [2:0]          out_status_q, out_status_d;
  logic [27:0]         out_faddr_q, out_faddr_d;
  logic                out_isal_q, out_isal_d;
  logic [FrameW-1:0]   out_free_q, out_free_d;

  // setup flags
  logic                base_unal, base_oob, hint_lt, rng_go;
  logic [40:0]         i0, i1raw;
  logic [FrameW-1:0]   i1c;
  // word flags
  logic [WordBits-1:0] rd_alloc, rd_usable, mask, cand;
  logic                found, last_word, bit_u, bit_a, slot_free;
  logic [BitW-1:0]     fbit, qbit;
  logic [FrameW-1:0]   hi_m1, free_idx;
  logic [BitW:0]       cnt;
  logic [FrameW:0]     sum_up;

  // request checks and range bounds
  always_comb begin
    base_unal = |base_q[11:0];
    base_oob  = (base_q >= AddrW'(max_phys_i)) || ({1'b0, base_q[AddrW-1:12]} >= 41'(eff_total_i));
    hint_lt   = hint_q < eff_total_i;
    if (op_q == OP_ADD) begin
      i0    = {1'b0, base_q[AddrW-1:12]} + 41'(|base_q[11:0]);
      i1raw = {1'b0, end_q[AddrW-1:12]};
    end else begin
      i0    = {1'b0, base_q[AddrW-1:12]};
      i1raw = {1'b0, end_q[AddrW-1:12]} + 41'(|end_q[11:0]);
    end
    i1c    = (i1raw > 41'(eff_total_i)) ? eff_total_i : i1raw[FrameW-1:0];
    rng_go = (end_q > base_q) && (i0 < 41'(i1c));
  end

  // map word decode
  always_comb begin
    rd_alloc  = mem_rdata_i[WordBits-1:0];
    rd_usable = mem_rdata_i[MemW-1:WordBits];
    mask      = word_mask(w_q, lo_q, hi_q);
    cand      = rd_usable & ~rd_alloc & mask;
    found     = |cand;
    fbit      = lowest_bit(cand);
    hi_m1     = hi_q - FrameW'(1);
    last_word = (w_q == hi_m1[FrameW-2:BitW]);
    qbit      = base_q[17:12];
    bit_u     = rd_usable[qbit];
    bit_a     = rd_alloc[qbit];
    free_idx  = {1'b0, w_q, qbit};
    if (op_q == OP_ADD) cnt = (BitW+1)'($countones(rd_alloc & mask));
    else                cnt = (BitW+1)'($countones(~rd_alloc & mask));
    sum_up    = {1'b0, free_q} + (FrameW+1)'(cnt);
    slot_free = !out_valid_q || !out_stall_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:   if (w_q == {WaddrW{1'b1}}) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_SETUP;
      S_SETUP: begin
        case (op_q) inside
          OP_ALLOC: begin
            if (free_q == '0) state_d = S_OUT;
            else if (hint_lt || eff_total_i != '0) state_d = S_MOD;
            else state_d = S_OUT;
          end
          OP_FREE, OP_QUERY: state_d = (base_unal || base_oob) ? S_OUT : S_MOD;
          OP_ADD, OP_RESERVE: state_d = rng_go ? S_MOD : S_OUT;
          default: state_d = S_OUT;
        endcase
      end
      S_MOD: begin
        case (op_q) inside
          OP_ALLOC: begin
            if (found) state_d = S_OUT;
            else if (last_word && (pass2_q || hint_q == '0)) state_d = S_OUT;
          end
          OP_ADD, OP_RESERVE: if (last_word) state_d = S_OUT;
          default: state_d = S_OUT;
        endcase
      end
      S_OUT:   if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and map writes
  always_comb begin
    op_d         = op_q;
    base_d       = base_q;
    end_d        = end_q;
    w_d          = w_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    pass2_d      = pass2_q;
    free_d       = free_q;
    hint_d       = hint_q;
    res_status_d = res_status_q;
    res_faddr_d  = res_faddr_q;
    res_isal_d   = res_isal_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_faddr_d  = out_faddr_q;
    out_isal_d   = out_isal_q;
    out_free_d   = out_free_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = w_q;
    mem_req_o.wdata = {rd_usable, rd_alloc};

    case (state_q)
      // clearing pass: every frame allocated and unusable
      S_CLR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.wdata = {{WordBits{1'b0}}, {WordBits{1'b1}}};
        w_d             = w_q + WaddrW'(1);
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = in_operation_i;
          base_d       = in_phys_addr_i;
          end_d        = in_range_end_i;
          res_status_d = ST_OK;
          res_faddr_d  = '0;
          res_isal_d   = 1'b0;
        end
      end
      S_SETUP: begin
        case (op_q) inside
          OP_ALLOC: begin
            if (free_q == '0) begin
              res_status_d = ST_OOM;
            end else if (hint_lt) begin
              lo_d    = hint_q;
              hi_d    = eff_total_i;
              w_d     = hint_q[FrameW-2:BitW];
              pass2_d = 1'b0;
            end else if (eff_total_i != '0) begin
              lo_d    = '0;
              hi_d    = eff_total_i;
              w_d     = '0;
              pass2_d = 1'b1;
            end else begin
              res_status_d = ST_CORRUPT;
            end
          end
          OP_FREE: begin
            if (base_unal) res_status_d = ST_UNALIGNED;
            else if (base_oob) res_status_d = ST_BOUNDS;
            else w_d = base_q[27:18];
          end
          OP_QUERY: begin
            if (base_unal || base_oob) res_isal_d = 1'b1;
            else w_d = base_q[27:18];
          end
          OP_ADD, OP_RESERVE: begin
            if (rng_go) begin
              lo_d = i0[FrameW-1:0];
              hi_d = i1c;
              w_d  = i0[FrameW-2:BitW];
            end
          end
          default: ;
        endcase
      end
      S_MOD: begin
        case (op_q)
          // next-fit search, one word per cycle
          OP_ALLOC: begin
            if (found) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.wdata = {rd_usable, rd_alloc | (WordBits'(1) << fbit)};
              free_d          = free_q - FrameW'(1);
              hint_d          = {1'b0, w_q, fbit} + FrameW'(1);
              res_faddr_d     = {w_q, fbit, 12'b0};
            end else if (last_word) begin
              if (!pass2_q && hint_q != '0) begin
                pass2_d = 1'b1;
                lo_d    = '0;
                hi_d    = hint_q;
                w_d     = '0;
              end else begin
                res_status_d = ST_CORRUPT;
              end
            end else begin
              w_d = w_q + WaddrW'(1);
            end
          end
          OP_FREE: begin
            if (!bit_u) begin
              res_status_d = ST_UNUSABLE;
            end else if (!bit_a) begin
              res_status_d = ST_DOUBLE;
            end else begin
              mem_req_o.we    = 1'b1;
              mem_req_o.wdata = {rd_usable, rd_alloc & ~(WordBits'(1) << qbit)};
              if (free_q < MAX_FRAMES_C) free_d = free_q + FrameW'(1);
              if (free_idx < hint_q) hint_d = free_idx;
            end
          end
          OP_QUERY: res_isal_d = bit_a;
          // usable range: mark usable, release allocated frames
          OP_ADD: begin
            mem_req_o.we    = 1'b1;
            mem_req_o.wdata = {rd_usable | mask, rd_alloc & ~mask};
            free_d = (sum_up > (FrameW+1)'(MaxFrames)) ? MAX_FRAMES_C : sum_up[FrameW-1:0];
            if (!last_word) w_d = w_q + WaddrW'(1);
          end
          // reserved range: take every free frame
          OP_RESERVE: begin
            mem_req_o.we    = 1'b1;
            mem_req_o.wdata = {rd_usable, rd_alloc | mask};
            free_d = (free_q > FrameW'(cnt)) ? free_q - FrameW'(cnt) : '0;
            if (!last_word) w_d = w_q + WaddrW'(1);
          end
          default: ;
        endcase
      end
      S_OUT: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_faddr_d  = res_faddr_q;
          out_isal_d   = res_isal_q;
          out_free_d   = free_q;
        end
      end
      default: ;
    endcase
    mem_req_o.raddr = w_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      w_q         <= '0;
      free_q      <= '0;
      hint_q      <= '0;
      out_valid_q <= 1'b0;
      pass2_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      w_q         <= w_d;
      free_q      <= free_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
      pass2_q     <= pass2_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    base_q       <= base_d;
    end_q        <= end_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    res_status_q <= res_status_d;
    res_faddr_q  <= res_faddr_d;
    res_isal_q   <= res_isal_d;
    out_status_q <= out_status_d;
    out_faddr_q  <= out_faddr_d;
    out_isal_q   <= out_isal_d;
    out_free_q   <= out_free_d;
  end

  assign in_stall_o            = (state_q != S_IDLE);
  assign out_valid_o           = out_valid_q;
  assign out_status_o          = out_status_q;
  assign out_frame_addr_o      = out_faddr_q;
  assign out_is_allocated_o    = out_isal_q;
  assign out_free_frames_now_o = out_free_q;

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpfa_pkg::*;

  localparam logic [2:0] OP_UNDEF_5 = 3'd5;
  localparam logic [2:0] OP_UNDEF_6 = 3'd6;
  localparam logic [2:0] OP_UNDEF_7 = 3'd7;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned HoldCycles = 2000;
  localparam logic [AddrW-1:0] AllOnes = {AddrW{1'b1}};
  localparam logic [AddrW-1:0] Pg = 52'd4096;

  typedef struct packed {
    logic [2:0]        status;
    logic [27:0]       frame_addr;
    logic              is_alloc;
    logic [FrameW-1:0] free_now;
  } alloc_res_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [AddrW-1:0] pa;
    logic [AddrW-1:0] re;
    logic             typed;
    alloc_res_t       want;
  } dir_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [2:0] in_op;
  logic [AddrW-1:0] in_pa, in_re;
  logic out_valid, out_stall;
  logic [2:0] out_status;
  logic [27:0] out_faddr;
  logic out_isal;
  logic [FrameW-1:0] out_free;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [MaxPhysW-1:0] cfg_data;

  bitmap_page_frame_allocator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_operation_i(in_op), .in_phys_addr_i(in_pa), .in_range_end_i(in_re),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_status_o(out_status), .out_frame_addr_o(out_faddr),
    .out_is_allocated_o(out_isal), .out_free_frames_now_o(out_free),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // shadow copy of the frame maps and counters
  bit alloc_m [MaxFrames];
  bit usable_m [MaxFrames];
  int unsigned free_cnt, hint;
  int unsigned total_cfg, maxphys_cfg;

  alloc_res_t result_q[$];
  int unsigned owned_frames[$];
  int unsigned errors, idle_cycles, burst_left;
  bit hold_go;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint unsigned eff_total();
    return (total_cfg < MaxFrames) ? total_cfg : MaxFrames;
  endfunction

  function automatic logic [2:0] addr_check(input logic [AddrW-1:0] a,
                                            output longint unsigned idx);
    idx = longint'(a) >> 12;
    if (a[11:0] != 12'd0) return ST_UNALIGNED;
    if (a >= AddrW'(maxphys_cfg) || idx >= eff_total()) return ST_BOUNDS;
    return ST_OK;
  endfunction

  // next-fit allocator behavior, one request
  function automatic alloc_res_t apply_request(input logic [2:0] op,
                                               input logic [AddrW-1:0] pa,
                                               input logic [AddrW-1:0] re);
    alloc_res_t r;
    longint unsigned tot, i, i0, i1, idx;
    bit found;
    logic [2:0] chk;
    tot = eff_total();
    r = '0;
    r.status = ST_OK;
    found = 1'b0;
    idx = 0;
    case (op)
      OP_ALLOC: begin
        if (free_cnt == 0) begin
          r.status = ST_OOM;
        end else begin
          for (i = hint; i < tot && !found; i++)
            if (usable_m[i] && !alloc_m[i]) begin
              found = 1'b1;
              idx = i;
            end
          for (i = 0; i < hint && i < tot && !found; i++)
            if (usable_m[i] && !alloc_m[i]) begin
              found = 1'b1;
              idx = i;
            end
          if (found) begin
            alloc_m[idx] = 1'b1;
            free_cnt--;
            hint = idx + 1;
            r.frame_addr = 28'(idx << 12);
          end else begin
            r.status = ST_CORRUPT;
          end
        end
      end
      OP_FREE: begin
        chk = addr_check(pa, idx);
        if (chk != ST_OK) r.status = chk;
        else if (!usable_m[idx]) r.status = ST_UNUSABLE;
        else if (!alloc_m[idx]) r.status = ST_DOUBLE;
        else begin
          alloc_m[idx] = 1'b0;
          if (free_cnt < MaxFrames) free_cnt++;
          if (idx < hint) hint = idx;
        end
      end
      OP_QUERY: begin
        if (addr_check(pa, idx) != ST_OK) r.is_alloc = 1'b1;
        else r.is_alloc = alloc_m[idx];
      end
      OP_ADD: begin
        if (re > pa) begin
          i0 = (longint'(pa) + 4095) >> 12;
          i1 = longint'(re) >> 12;
          if (i1 > tot) i1 = tot;
          for (i = i0; i < i1; i++) begin
            usable_m[i] = 1'b1;
            if (alloc_m[i]) begin
              alloc_m[i] = 1'b0;
              if (free_cnt < MaxFrames) free_cnt++;
            end
          end
        end
      end
      OP_RESERVE: begin
        if (re > pa) begin
          i0 = longint'(pa) >> 12;
          i1 = (longint'(re) + 4095) >> 12;
          if (i1 > tot) i1 = tot;
          for (i = i0; i < i1; i++)
            if (!alloc_m[i]) begin
              alloc_m[i] = 1'b1;
              if (free_cnt != 0) free_cnt--;
            end
        end
      end
      default: ;
    endcase
    r.free_now = FrameW'(free_cnt);
    return r;
  endfunction

  task automatic report_err(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // one request through the input channel, with bursty gaps
  task automatic push_req(input logic [2:0] op, input logic [AddrW-1:0] pa,
                          input logic [AddrW-1:0] re, input bit typed,
                          input alloc_res_t want);
    alloc_res_t got;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op <= op;
    in_pa <= pa;
    in_re <= re;
    do @(posedge clk); while (in_stall);
    got = apply_request(op, pa, re);
    result_q.push_back(typed ? want : got);
    if (op == OP_ALLOC && got.status == ST_OK) owned_frames.push_back(got.frame_addr >> 12);
  endtask

  // settle, then write both registers back to back
  task automatic set_config(input int unsigned tot, input int unsigned maxp);
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TOTAL_FRAMES;
    cfg_data <= MaxPhysW'(tot);
    do @(posedge clk); while (!cfg_ready);
    total_cfg = tot;
    cfg_index <= CFG_MAX_PHYS;
    cfg_data <= MaxPhysW'(maxp);
    do @(posedge clk); while (!cfg_ready);
    maxphys_cfg = maxp;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [AddrW-1:0] pick_addr();
    int unsigned k;
    logic [AddrW-1:0] a;
    k = $urandom_range(0, 99);
    a = AddrW'($urandom_range(0, int'(eff_total()) + 4)) << 12;
    if (k < 15) a = a + AddrW'($urandom_range(1, 4095));
    else if (k < 25) a = AddrW'({$urandom(), $urandom()});
    return a;
  endfunction

  // random request mix, mostly well-formed alloc/free traffic
  task automatic random_req();
    int unsigned k, len;
    logic [2:0] op;
    logic [AddrW-1:0] pa, re;
    k = $urandom_range(0, 99);
    pa = pick_addr();
    len = ($urandom_range(0, 9) == 0) ? int'(eff_total()) : $urandom_range(0, 80);
    re = pa + AddrW'(len) * Pg;
    if ($urandom_range(0, 3) == 0) re = re + AddrW'($urandom_range(0, 4095)) - 52'd2048;
    if (k < 30) op = OP_ALLOC;
    else if (k < 55) begin
      op = OP_FREE;
      if (owned_frames.size() != 0 && $urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, owned_frames.size() - 1);
        pa = AddrW'(owned_frames[k]) << 12;
        owned_frames.delete(k);
      end
    end
    else if (k < 68) op = OP_QUERY;
    else if (k < 80) op = OP_ADD;
    else if (k < 90) op = OP_RESERVE;
    else begin
      op = 3'($urandom_range(0, 7));
      pa = AddrW'({$urandom(), $urandom()});
      re = AddrW'({$urandom(), $urandom()});
    end
    push_req(op, pa, re, 1'b0, '0);
  endtask

  // stimulus
  initial begin
    dir_row_t dir_tab [25];
    int unsigned ph_total [5];
    int unsigned ph_max [5];
    int unsigned ph_items [5];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_ALLOC;
    in_pa = '0;
    in_re = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TOTAL_FRAMES;
    cfg_data = '0;
    errors = 0;
    burst_left = 0;
    hold_go = 1'b0;
    for (int i = 0; i < MaxFrames; i++) begin
      alloc_m[i] = 1'b1;
      usable_m[i] = 1'b0;
    end
    free_cnt = 0;
    hint = 0;
    total_cfg = 65536;
    maxphys_cfg = 268435456;

    dir_tab = '{
      '{OP_QUERY, 52'd0, 52'd0, 1'b1, '{ST_OK, 28'd0, 1'b1, 17'd0}},
      '{OP_ALLOC, 52'd0, 52'd0, 1'b1, '{ST_OOM, 28'd0, 1'b0, 17'd0}},
      '{OP_FREE, 52'd1, 52'd0, 1'b1, '{ST_UNALIGNED, 28'd0, 1'b0, 17'd0}},
      '{OP_FREE, 52'h10000000, 52'd0, 1'b1, '{ST_BOUNDS, 28'd0, 1'b0, 17'd0}},
      '{OP_FREE, 52'd0, 52'd0, 1'b1, '{ST_UNUSABLE, 28'd0, 1'b0, 17'd0}},
      '{OP_FREE, AllOnes, AllOnes, 1'b1, '{ST_UNALIGNED, 28'd0, 1'b0, 17'd0}},
      '{OP_QUERY, AllOnes, 52'd0, 1'b1, '{ST_OK, 28'd0, 1'b1, 17'd0}},
      '{OP_ADD, 52'd0, 52'h40000, 1'b1, '{ST_OK, 28'd0, 1'b0, 17'd64}},
      '{OP_ALLOC, 52'd0, 52'd0, 1'b1, '{ST_OK, 28'd0, 1'b0, 17'd63}},
      '{OP_ALLOC, 52'd0, 52'd0, 1'b1, '{ST_OK, 28'd4096, 1'b0, 17'd62}},
      '{OP_FREE, 52'd0, 52'd0, 1'b1, '{ST_OK, 28'd0, 1'b0, 17'd63}},
      '{OP_FREE, 52'd0, 52'd0, 1'b1, '{ST_DOUBLE, 28'd0, 1'b0, 17'd63}},
      '{OP_QUERY, 52'd4096, 52'd0, 1'b1, '{ST_OK, 28'd0, 1'b1, 17'd63}},
      '{OP_RESERVE, 52'd4097, 52'd8193, 1'b0, '0},
      '{OP_ADD, 52'd4095, 52'd4096, 1'b0, '0},
      '{OP_ADD, 52'd8192, 52'd8192, 1'b0, '0},
      '{OP_UNDEF_5, 52'd0, 52'd0, 1'b0, '0},
      '{OP_UNDEF_6, AllOnes, 52'd0, 1'b0, '0},
      '{OP_UNDEF_7, AllOnes, AllOnes, 1'b0, '0},
      '{OP_RESERVE, 52'd0, AllOnes, 1'b0, '0},
      '{OP_ALLOC, 52'd0, 52'd0, 1'b0, '0},
      '{OP_ADD, 52'd0, AllOnes, 1'b0, '0},
      '{OP_RESERVE, 52'h64000, 52'h10000fff, 1'b0, '0},
      '{OP_FREE, 52'hffff000, 52'd0, 1'b0, '0},
      '{OP_ALLOC, 52'd0, 52'd0, 1'b0, '0}
    };
    ph_total = '{65536, 256, 1, 300, 65536};
    ph_max = '{268435456, 268435456, 0, 200 * 4096 + 5, 268435456};
    ph_items = '{150, 450, 60, 400, 150};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows at reset configuration
    foreach (dir_tab[i])
      push_req(dir_tab[i].op, dir_tab[i].pa, dir_tab[i].re, dir_tab[i].typed, dir_tab[i].want);

    // random phases, each under its own configuration
    for (int p = 0; p < 5; p++) begin
      set_config(ph_total[p], ph_max[p]);
      for (int n = 0; n < ph_items[p]; n++) begin
        if (p == 1 && n == 20) hold_go = 1'b1;
        random_req();
      end
    end
    in_valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("[bitmap_page_frame_allocator] OK");
    else $display("[bitmap_page_frame_allocator] ERROR");
    $finish;
  end

  // result side stall pattern with one long hold-off
  initial begin
    int unsigned mode;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(50, 300)) begin
        @(posedge clk);
        if (hold_go) begin
          hold_go = 1'b0;
          out_stall <= 1'b1;
          repeat (HoldCycles) @(posedge clk);
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    alloc_res_t exp_r;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout waiting for a request");
      $display("[bitmap_page_frame_allocator] ERROR");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        report_err("unexpected result, status", out_status, -1);
      end else begin
        exp_r = result_q.pop_front();
        if (out_status !== exp_r.status) report_err("status", out_status, exp_r.status);
        if (out_faddr !== exp_r.frame_addr) report_err("frame_addr", out_faddr, exp_r.frame_addr);
        if (out_isal !== exp_r.is_alloc) report_err("is_allocated", out_isal, exp_r.is_alloc);
        if (out_free !== exp_r.free_now) report_err("free_frames", out_free, exp_r.free_now);
      end
    end
  end

  initial idle_cycles = 0;

endmodule
